### rtl/hftd_pkg.sv
// package for the humidity and temperature frame decoder
// holds byte positions, crc status codes, register indexes, scaling constants and the crc-8 step
// no dependencies
`default_nettype none

package hftd_pkg;

   typedef logic [2:0] byte_pos_type;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam byte_pos_type POS_TEMP_HI  = 3'd0;
   localparam byte_pos_type POS_TEMP_LO  = 3'd1;
   localparam byte_pos_type POS_TEMP_CRC = 3'd2;
   localparam byte_pos_type POS_HUM_HI   = 3'd3;
   localparam byte_pos_type POS_HUM_LO   = 3'd4;
   localparam byte_pos_type POS_HUM_CRC  = 3'd5;

   localparam logic [1:0] CRC_OK       = 2'd0;
   localparam logic [1:0] CRC_BAD_TEMP = 2'd1;
   localparam logic [1:0] CRC_BAD_HUM  = 2'd2;

   localparam logic CSR_TEMP_LIMIT = 1'b0;
   localparam logic CSR_HUM_LIMIT  = 1'b1;

   localparam logic [14:0] TEMP_LIMIT_RESET = 15'd3000;
   localparam logic [13:0] HUM_LIMIT_RESET  = 14'd7000;

   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [13:0] HUM_SPAN    = 14'd10000;

   // crc-8, msb first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/hftd_scale.sv
// raw sensor word to hundredths: floor(span * raw / 65535), span picked for temperature or humidity
// depends on hftd_pkg
`default_nettype none

module hftd_scale import hftd_pkg::*; (
   input  wire logic [15:0] raw_word,
   input  wire logic        temp_sel,
   output logic      [14:0] scaled
);

   logic [14:0] gain;
   logic [30:0] product;
   logic [30:0] rounded;

   always_comb begin
      gain    = temp_sel ? TEMP_SPAN : {1'b0, HUM_SPAN};
      product = 31'(raw_word) * 31'(gain);
      // x / 65535 == (x + (x >> 16) + 1) >> 16 over this range
      rounded = product + 31'(product[30:16]) + 31'd1;
      scaled  = rounded[30:16];
   end

endmodule

`default_nettype wire

### rtl/humidity_temp_frame_decoder.sv
// top level of the humidity and temperature frame decoder
// depends on hftd_pkg and hftd_scale
//
// req channel: one sensor byte per transaction, req_frame_start marks the first byte
// of a six-byte frame (temperature word, crc, humidity word, crc) and resynchronizes
// the byte count; without a mark the count wraps after the sixth byte.
// rsp channel: one transaction per complete frame with the last good temperature
// (hundredths of a degree), humidity (hundredths of a percent), crc status and alarm.
// csr port: index 0 temperature alarm limit, index 1 humidity alarm limit.
// throughput: one byte per cycle while req_stall is low; the word scaling runs on
// the byte that completes each word, so the frame's last byte only does compares.
// the result is registered: on rsp in the cycle after the sixth byte is taken.
// the result register holds until taken; bytes of the next frame keep flowing, and
// only a byte that arrives with the count at the sixth position (the frame's last
// byte, or a marked byte there) waits (req_stall) while the previous result is held.
// reset: byte count at the frame start, crc preset, good values and alarm zero,
// limits at 3000 and 7000, rsp_valid low.
`default_nettype none

module humidity_temp_frame_decoder import hftd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_frame_start,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [14:0] rsp_temp_centideg,
   output logic      [13:0] rsp_hum_centipct,
   output logic      [1:0]  rsp_crc_status,
   output logic             rsp_alarm,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [14:0] csr_wdata
);

   byte_pos_type byte_position_ff, byte_position_in;
   logic [7:0]   running_crc_ff, running_crc_in;
   logic [1:0]   frame_error_ff, frame_error_in;
   logic [7:0]   word_hi_ff, word_hi_in;
   logic [14:0]  temp_new_ff, temp_new_in;
   logic [13:0]  hum_new_ff, hum_new_in;
   logic [14:0]  temp_limit_ff, temp_limit_in;
   logic [13:0]  hum_limit_ff, hum_limit_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [14:0]  rsp_temp_ff, rsp_temp_in;
   logic [13:0]  rsp_hum_ff, rsp_hum_in;
   logic [1:0]   rsp_status_ff, rsp_status_in;
   logic         rsp_alarm_ff, rsp_alarm_in;

   logic         accept;
   byte_pos_type pos;
   logic [7:0]   crc_base;
   logic [7:0]   crc_next;
   logic [14:0]  scaled;
   logic [1:0]   final_error;

   assign req_stall = rsp_valid_ff && (byte_position_ff >= POS_HUM_CRC);
   assign accept    = req_valid && !req_stall;
   assign pos       = req_frame_start ? POS_TEMP_HI : byte_position_ff;

   hftd_scale u_scale (
      .raw_word (({word_hi_ff, req_rx_byte})),
      .temp_sel (pos == POS_TEMP_LO),
      .scaled   (scaled)
   );

   always_comb begin
      crc_base = (pos inside {POS_TEMP_HI, POS_HUM_HI}) ? CRC_INIT : running_crc_ff;
      crc_next = crc8_byte(crc_base, req_rx_byte);
   end

   always_comb begin
      byte_position_in = byte_position_ff;
      running_crc_in   = running_crc_ff;
      frame_error_in   = frame_error_ff;
      word_hi_in       = word_hi_ff;
      temp_new_in      = temp_new_ff;
      hum_new_in       = hum_new_ff;
      temp_limit_in    = temp_limit_ff;
      hum_limit_in     = hum_limit_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_temp_in      = rsp_temp_ff;
      rsp_hum_in       = rsp_hum_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_alarm_in     = rsp_alarm_ff;
      final_error      = frame_error_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_TEMP_LIMIT: temp_limit_in = csr_wdata;
            CSR_HUM_LIMIT:  hum_limit_in  = csr_wdata[13:0];
            default: ;
         endcase
      end

      if (accept) begin
         byte_position_in = pos + 3'd1;
         case (pos)
            POS_TEMP_HI: begin
               frame_error_in = CRC_OK;
               word_hi_in     = req_rx_byte;
               running_crc_in = crc_next;
            end
            POS_TEMP_LO: begin
               temp_new_in    = scaled - TEMP_OFFSET;
               running_crc_in = crc_next;
            end
            POS_TEMP_CRC: begin
               if (req_rx_byte != running_crc_ff) begin
                  frame_error_in = CRC_BAD_TEMP;
               end
               running_crc_in = CRC_INIT;
            end
            POS_HUM_HI: begin
               word_hi_in     = req_rx_byte;
               running_crc_in = crc_next;
            end
            POS_HUM_LO: begin
               hum_new_in     = scaled[13:0];
               running_crc_in = crc_next;
            end
            default: begin
               if (frame_error_ff == CRC_OK && req_rx_byte != running_crc_ff) begin
                  final_error = CRC_BAD_HUM;
               end
               if (final_error == CRC_OK) begin
                  rsp_temp_in  = temp_new_ff;
                  rsp_hum_in   = hum_new_ff;
                  rsp_alarm_in = ($signed(temp_new_ff) >= $signed(temp_limit_ff))
                                 || (hum_new_ff >= hum_limit_ff);
               end
               frame_error_in   = final_error;
               rsp_status_in    = final_error;
               rsp_valid_in     = 1'b1;
               running_crc_in   = CRC_INIT;
               byte_position_in = POS_TEMP_HI;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= POS_TEMP_HI;
         running_crc_ff   <= CRC_INIT;
         frame_error_ff   <= CRC_OK;
         temp_limit_ff    <= TEMP_LIMIT_RESET;
         hum_limit_ff     <= HUM_LIMIT_RESET;
         rsp_valid_ff     <= 1'b0;
         rsp_temp_ff      <= '0;
         rsp_hum_ff       <= '0;
         rsp_status_ff    <= CRC_OK;
         rsp_alarm_ff     <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         running_crc_ff   <= running_crc_in;
         frame_error_ff   <= frame_error_in;
         temp_limit_ff    <= temp_limit_in;
         hum_limit_ff     <= hum_limit_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_temp_ff      <= rsp_temp_in;
         rsp_hum_ff       <= rsp_hum_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_alarm_ff     <= rsp_alarm_in;
      end
   end

   always_ff @(posedge clock) begin
      word_hi_ff  <= word_hi_in;
      temp_new_ff <= temp_new_in;
      hum_new_ff  <= hum_new_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_temp_centideg = rsp_temp_ff;
   assign rsp_hum_centipct  = rsp_hum_ff;
   assign rsp_crc_status    = rsp_status_ff;
   assign rsp_alarm         = rsp_alarm_ff;

endmodule

`default_nettype wire

### rtl/hftd_checker.sv
// port-level assertions for the humidity and temperature frame decoder
// depends on hftd_pkg; bound to humidity_temp_frame_decoder at the end of this file
`default_nettype none

module hftd_checker import hftd_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [14:0] rsp_temp_centideg,
   input wire logic [13:0] rsp_hum_centipct,
   input wire logic [1:0]  rsp_crc_status,
   input wire logic        rsp_alarm
);

   // held result stays put while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temp_centideg)
         && $stable(rsp_hum_centipct) && $stable(rsp_crc_status) && $stable(rsp_alarm))
      else $error("rsp transaction changed while stalled");

   // only a held result can block the byte side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with no result held");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_crc_status == CRC_OK || rsp_crc_status == CRC_BAD_TEMP
         || rsp_crc_status == CRC_BAD_HUM)
      else $error("bad crc status code");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hum_centipct <= HUM_SPAN)
      else $error("humidity above full scale");

endmodule

bind humidity_temp_frame_decoder hftd_checker u_hftd_checker (.*);

`default_nettype wire
